// ===== hw/rtl/srr_pkg.sv =====
// Shared types and constants for the selective repeat receiver core.
`timescale 1ns / 1ps

package srr_pkg;

  // Packet geometry of the sequence space.
  localparam int PKT_BYTES      = 972;
  localparam int WINDOW_DEFAULT = 5;

  // Field widths.
  localparam int SEQ_W   = 15;
  localparam int WRAP_W  = 16;
  localparam int HAND_W  = 16;
  localparam int BYTES_W = 10;
  localparam int NEXT_W  = 22;
  localparam int KIND_W  = 3;
  localparam int FIN_W   = 2;
  localparam int TYPE_W  = 2;

  // Index geometry: the dividend seq + wraps*30720 fits in 31 bits. Since
  // 972 = 4 * 243, the dividend is shifted right by two and multiplied by
  // ceil(2^37 / 243); the NEXT_W product bits from bit 37 up are the index.
  localparam int PROD_W    = WRAP_W + 4;
  localparam int DIV_W     = 31;
  localparam int RECIP_W   = 30;
  localparam logic [RECIP_W-1:0] RECIP_243 = 30'd565592402;
  localparam int QUO_SHIFT = 37;
  localparam int MULT_W    = DIV_W - 2 + RECIP_W;

  // Stream widths.
  localparam int S_DATA_W = 64;
  localparam int S_USER_W = 5;
  localparam int M_DATA_W = 64;
  localparam int M_USER_W = KIND_W;

  // Fin codes that change behavior.
  localparam logic [FIN_W-1:0] FIN_FINAL = 2'd1;
  localparam logic [FIN_W-1:0] FIN_SYN   = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK       = 3'd0,
    KIND_REACK     = 3'd1,
    KIND_SYN_ECHO  = 3'd2,
    KIND_DELIVER   = 3'd3,
    KIND_NOT_FOUND = 3'd4,
    KIND_CLOSE     = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_CMP,
    ST_ACK,
    ST_DELIVER,
    ST_REACK,
    ST_SYN,
    ST_NOT_FOUND,
    ST_CLOSE
  } state_t;

  // One result as it is loaded into the output register.
  typedef struct packed {
    logic                load;
    kind_t               kind;
    logic [SEQ_W-1:0]    seq;
    logic [WRAP_W-1:0]   wraps;
    logic [HAND_W-1:0]   handle;
    logic [BYTES_W-1:0]  bytes;
    logic                last;
  } result_t;

endpackage

// ===== hw/rtl/selective_repeat_receiver_core.sv =====
// Top level of the selective repeat receiver: packet index divider, window slots, result sequencer.
`timescale 1ns / 1ps

// The block takes one received packet header per request on the s_ channel and
// returns the results it causes on the m_ channel, with m_tlast marking the
// last result of the header. Headers carry the error flag, fin code and packet
// type in s_tuser; the result kind travels in m_tuser.
//
// An error header or a SYN moves to its NOT_FOUND or SYN state, which loads
// its single result into the output register and returns to idle for the next
// header. Any other header first has its packet index (seq + wraps*30720)/972
// worked out in the MUL, SUM, DIV and CMP states: wraps*15 by shift and subtract,
// the sum, one reciprocal multiply by 1/243 of the dividend shifted right by two,
// and the window compare. Its first result, if any, is then loaded into the output
// register; further results (in-order deliveries, then a close) follow one per
// cycle while the downstream takes them, and the next header is taken once its
// results are out.
//
// Reset clears the window base, every slot valid bit and the session state.
// When the downstream stalls, the pending result holds in the output register
// and the sequencer waits; after a not-found or close result every header is
// accepted and dropped until reset.
module selective_repeat_receiver_core #(
  parameter int WINDOW = srr_pkg::WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // byte_sequence[14:0], wrap_count[30:15], payload_handle[46:31],
  // payload_bytes[56:47], zero fill above
  input  logic [srr_pkg::S_DATA_W-1:0]  s_tdata,
  // error_flag[0], fin_code[2:1], packet_type[4:3]
  input  logic [srr_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // ack_sequence[14:0], ack_wraps[30:15], deliver_handle[46:31],
  // deliver_bytes[56:47], zero fill above
  output logic [srr_pkg::M_DATA_W-1:0]  m_tdata,
  // result_kind[2:0]
  output logic [srr_pkg::M_USER_W-1:0]  m_tuser,
  output logic                          m_tlast
);

  localparam int SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  srr_pkg::state_t state, state_next;

  // Latched header fields.
  logic [srr_pkg::SEQ_W-1:0]   in_seq;
  logic [srr_pkg::WRAP_W-1:0]  in_wraps;
  logic [srr_pkg::HAND_W-1:0]  in_handle;
  logic [srr_pkg::BYTES_W-1:0] in_bytes;
  logic [srr_pkg::FIN_W-1:0]   in_fin;

  // Index state: dq holds the dividend, then the packet index.
  logic [srr_pkg::PROD_W-1:0]    prod;
  logic [srr_pkg::DIV_W-1:0]     dq;
  logic [srr_pkg::MULT_W-1:0]    recip_prod;

  // Window state.
  logic [srr_pkg::NEXT_W-1:0]  next_expected;
  logic [WINDOW-1:0]           slot_valid;
  logic [srr_pkg::HAND_W-1:0]  slot_handle [WINDOW];
  logic [srr_pkg::BYTES_W-1:0] slot_bytes  [WINDOW];
  logic                        session_over;

  // Final packet test for the emit states.
  logic                        is_final;

  logic                        s_accept;
  logic                        out_free;
  logic                        in_err;
  logic [srr_pkg::FIN_W-1:0]   in_fin_w;
  logic [srr_pkg::SEQ_W-1:0]   in_seq_w;

  logic signed [31:0]          diff;
  logic                        in_window;
  logic                        behind;
  logic [SlotW-1:0]            slot_idx;
  logic [WINDOW-1:0]           valid_after;

  srr_pkg::result_t res;

  assign s_tready = (state == srr_pkg::ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign in_err   = s_tuser[0];
  assign in_fin_w = s_tuser[2:1];
  assign in_seq_w = s_tdata[14:0];

  // Reciprocal multiply: dividend / 4 times ceil(2^37 / 243).
  assign recip_prod = {{srr_pkg::RECIP_W{1'b0}}, dq[srr_pkg::DIV_W-1:2]} *
                      {{(srr_pkg::DIV_W-2){1'b0}}, srr_pkg::RECIP_243};

  // Distance of the packet index from the window base.
  assign diff      = $signed({1'b0, dq}) - $signed({10'b0, next_expected});
  assign in_window = !diff[31] && (diff < 32'(WINDOW));
  assign behind    = diff[31] && (diff >= -32'(WINDOW));
  assign slot_idx  = diff[SlotW-1:0];

  // Valid bits as they stand after one slide of the window.
  assign valid_after = slot_valid >> 1;

  assign is_final = (in_fin == srr_pkg::FIN_FINAL);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      srr_pkg::ST_IDLE: begin
        if (s_accept && !session_over) begin
          if (in_err) begin
            state_next = srr_pkg::ST_NOT_FOUND;
          end else if (in_seq_w == '0 && in_fin_w == srr_pkg::FIN_SYN) begin
            state_next = srr_pkg::ST_SYN;
          end else begin
            state_next = srr_pkg::ST_MUL;
          end
        end
      end
      srr_pkg::ST_MUL: state_next = srr_pkg::ST_SUM;
      srr_pkg::ST_SUM: state_next = srr_pkg::ST_DIV;
      srr_pkg::ST_DIV: state_next = srr_pkg::ST_CMP;
      srr_pkg::ST_CMP: begin
        if (in_window) begin
          state_next = srr_pkg::ST_ACK;
        end else if (behind) begin
          state_next = srr_pkg::ST_REACK;
        end else if (is_final) begin
          state_next = srr_pkg::ST_CLOSE;
        end else begin
          state_next = srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_ACK, srr_pkg::ST_DELIVER: begin
        if (out_free) begin
          if ((state == srr_pkg::ST_ACK) ? slot_valid[0] : valid_after[0]) begin
            state_next = srr_pkg::ST_DELIVER;
          end else if (is_final) begin
            state_next = srr_pkg::ST_CLOSE;
          end else begin
            state_next = srr_pkg::ST_IDLE;
          end
        end
      end
      srr_pkg::ST_REACK: begin
        if (out_free) begin
          state_next = is_final ? srr_pkg::ST_CLOSE : srr_pkg::ST_IDLE;
        end
      end
      srr_pkg::ST_SYN, srr_pkg::ST_NOT_FOUND, srr_pkg::ST_CLOSE: begin
        if (out_free) begin
          state_next = srr_pkg::ST_IDLE;
        end
      end
      default: state_next = srr_pkg::ST_IDLE;
    endcase
  end

  // Result selection for the output register.
  always_comb begin
    res        = '0;
    res.kind   = srr_pkg::KIND_ACK;
    case (state)
      srr_pkg::ST_ACK: begin
        res.load  = out_free;
        res.kind  = srr_pkg::KIND_ACK;
        res.seq   = in_seq;
        res.wraps = in_wraps;
        res.last  = !slot_valid[0] && !is_final;
      end
      srr_pkg::ST_DELIVER: begin
        res.load   = out_free;
        res.kind   = srr_pkg::KIND_DELIVER;
        res.handle = slot_handle[0];
        res.bytes  = slot_bytes[0];
        res.last   = !valid_after[0] && !is_final;
      end
      srr_pkg::ST_REACK: begin
        res.load  = out_free;
        res.kind  = srr_pkg::KIND_REACK;
        res.seq   = in_seq;
        res.wraps = in_wraps;
        res.last  = !is_final;
      end
      srr_pkg::ST_SYN: begin
        res.load  = out_free;
        res.kind  = srr_pkg::KIND_SYN_ECHO;
        res.seq   = in_seq;
        res.wraps = in_wraps;
        res.last  = 1'b1;
      end
      srr_pkg::ST_NOT_FOUND: begin
        res.load = out_free;
        res.kind = srr_pkg::KIND_NOT_FOUND;
        res.last = 1'b1;
      end
      srr_pkg::ST_CLOSE: begin
        res.load = out_free;
        res.kind = srr_pkg::KIND_CLOSE;
        res.last = 1'b1;
      end
      default: res.load = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= srr_pkg::ST_IDLE;
      next_expected <= '0;
      slot_valid    <= '0;
      session_over  <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (res.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (res.load && (state == srr_pkg::ST_NOT_FOUND || state == srr_pkg::ST_CLOSE)) begin
        session_over <= 1'b1;
      end
      if (state == srr_pkg::ST_CMP && in_window) begin
        slot_valid[slot_idx] <= 1'b1;
      end else if (state == srr_pkg::ST_DELIVER && res.load) begin
        slot_valid    <= valid_after;
        next_expected <= next_expected + srr_pkg::NEXT_W'(1);
      end
    end
  end

  // Payload registers: header latch, index unit, slot data and output data.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_seq    <= in_seq_w;
      in_wraps  <= s_tdata[30:15];
      in_handle <= s_tdata[46:31];
      in_bytes  <= s_tdata[56:47];
      in_fin    <= in_fin_w;
    end
    // wraps*15, then shifted by 11 below to give wraps*30720.
    if (state == srr_pkg::ST_MUL) begin
      prod <= {in_wraps, 4'b0} - {4'b0, in_wraps};
    end
    if (state == srr_pkg::ST_SUM) begin
      dq <= {prod, 11'b0} + {16'b0, in_seq};
    end else if (state == srr_pkg::ST_DIV) begin
      dq <= {{(srr_pkg::DIV_W-srr_pkg::NEXT_W){1'b0}},
             recip_prod[srr_pkg::MULT_W-1:srr_pkg::QUO_SHIFT]};
    end
    if (state == srr_pkg::ST_CMP && in_window) begin
      slot_handle[slot_idx] <= in_handle;
      slot_bytes[slot_idx]  <= in_bytes;
    end else if (state == srr_pkg::ST_DELIVER && res.load) begin
      for (int i = 0; i < WINDOW - 1; i++) begin
        slot_handle[i] <= slot_handle[i + 1];
        slot_bytes[i]  <= slot_bytes[i + 1];
      end
    end
    if (res.load) begin
      m_tdata <= {7'b0, res.bytes, res.handle, res.wraps, res.seq};
      m_tuser <= res.kind;
      m_tlast <= res.last;
    end
  end

endmodule
